// ----- rtl/sws_pkg.sv -----
// Shared types, constants and helpers for the sliding window sum/average/median block.
// Depends on nothing; used by every module under rtl/.
package sws_pkg;

   // Window storage depth and derived widths
   localparam int MAX_WINDOW = 64;
   localparam int SAMPLE_W   = 32;
   localparam int SUM_W      = 38;
   localparam int WLEN_W     = 7;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W      = $clog2(MAX_WINDOW);
   localparam int ACC_W      = SAMPLE_W + CNT_W;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;

   // Input action codes
   localparam logic ACTION_PUSH  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT_RD,
      ST_EVICT_UPD,
      ST_APPEND,
      ST_START,
      ST_SWEEP,
      ST_RANK,
      ST_FINISH
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic clear;
      logic evict_rd;
      logic evict;
      logic append;
      logic start;
      logic sweep;
      logic rank;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full;
      logic sweep_done;
      logic last_cand;
      logic div_done;
      logic rsp_free;
   } dp_sts_type;

   // Circular index: base + offset, wrapped once into the store depth
   function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
      logic [PTR_W:0] s;
      s = (PTR_W+1)'(base) + (PTR_W+1)'(off);
      if (s >= (PTR_W+1)'(MAX_WINDOW)) begin
         s = s - (PTR_W+1)'(MAX_WINDOW);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

// ----- rtl/sliding_window_sum_average_median.sv -----
// Sliding window sum, average and median over signed Q16.16 samples. Each input
// transaction (push or clear) yields one result transaction with count, exact sum,
// mean (truncated toward zero) and median. One transaction is processed at a time.
// A push passes through an extra eviction update state when the oldest sample is
// dropped. Its time is set by whichever is longer: the rank-count median, which
// sweeps the sample store once per candidate through its second read port, or the
// serial divider, which runs alongside. A clear goes straight to the result load.
// A new request is accepted while the previous result still
// waits in the output register; the next result then waits for that one to leave.
// Depends on sws_pkg, sws_ctrl, sws_datapath and sws_div.
module sliding_window_sum_average_median (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sws_pkg::WLEN_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic signed [sws_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sws_pkg::WLEN_W-1:0]           rsp_count,
   output logic signed [sws_pkg::SUM_W-1:0]     rsp_window_sum,
   output logic signed [sws_pkg::SAMPLE_W-1:0]  rsp_mean,
   output logic signed [sws_pkg::SAMPLE_W-1:0]  rsp_middle_value
);

   sws_pkg::dp_cmd_type cmd;
   sws_pkg::dp_sts_type sts;

   sws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sws_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_count        (rsp_count),
      .rsp_window_sum   (rsp_window_sum),
      .rsp_mean         (rsp_mean),
      .rsp_middle_value (rsp_middle_value)
   );

endmodule

// ----- rtl/sws_div.sv -----
// Serial signed divider: running sum over sample count, truncated toward zero.
// One quotient bit per cycle. Depends on sws_pkg.
module sws_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [sws_pkg::ACC_W-1:0]     dividend,
   input  logic        [sws_pkg::CNT_W-1:0]     divisor,
   output logic                                 done,
   output logic signed [sws_pkg::SAMPLE_W-1:0]  quotient
);

   localparam int ITER_W = $clog2(sws_pkg::ACC_W + 1);

   logic                         busy_ff;
   logic [ITER_W-1:0]            iter_ff;
   logic [sws_pkg::CNT_W-1:0]    rem_ff;
   logic [sws_pkg::ACC_W-1:0]    quo_ff;
   logic [sws_pkg::CNT_W-1:0]    dvs_ff;
   logic                         neg_ff;

   logic [sws_pkg::ACC_W-1:0]    mag;
   logic [sws_pkg::CNT_W:0]      shifted;
   logic [sws_pkg::CNT_W:0]      diff;
   logic                         qbit;
   logic [sws_pkg::ACC_W-1:0]    quo_signed;

   // Magnitude of the dividend
   always_comb begin
      mag = dividend[sws_pkg::ACC_W-1] ? (~dividend + 1'b1) : dividend;
   end

   // Restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[sws_pkg::ACC_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      qbit    = (shifted >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= ITER_W'(sws_pkg::ACC_W);
      end else if (busy_ff) begin
         iter_ff <= iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= mag;
         rem_ff <= '0;
         dvs_ff <= divisor;
         neg_ff <= dividend[sws_pkg::ACC_W-1];
      end else if (busy_ff) begin
         rem_ff <= qbit ? diff[sws_pkg::CNT_W-1:0] : shifted[sws_pkg::CNT_W-1:0];
         quo_ff <= {quo_ff[sws_pkg::ACC_W-2:0], qbit};
      end
   end

   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = quo_signed[sws_pkg::SAMPLE_W-1:0];
   assign done       = ~busy_ff & ~start;

endmodule

// ----- rtl/sws_datapath.sv -----
// Datapath: sample store, running sum, rank-count median search, divider, result register.
// Depends on sws_pkg and sws_div.
module sws_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sws_pkg::dp_cmd_type                  cmd,
   output sws_pkg::dp_sts_type                  sts,
   input  logic                                 csr_write_en,
   input  logic [sws_pkg::WLEN_W-1:0]           csr_write_data,
   input  logic signed [sws_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sws_pkg::WLEN_W-1:0]           rsp_count,
   output logic signed [sws_pkg::SUM_W-1:0]     rsp_window_sum,
   output logic signed [sws_pkg::SAMPLE_W-1:0]  rsp_mean,
   output logic signed [sws_pkg::SAMPLE_W-1:0]  rsp_middle_value
);

   logic [sws_pkg::WLEN_W-1:0]           wlen_ff;
   logic [sws_pkg::CNT_W-1:0]            held_ff;
   logic [sws_pkg::PTR_W-1:0]            ptr_ff;
   logic signed [sws_pkg::ACC_W-1:0]     sum_ff;
   logic signed [sws_pkg::SAMPLE_W-1:0]  sample_ff;

   logic signed [sws_pkg::SAMPLE_W-1:0]  mem [sws_pkg::MAX_WINDOW];
   logic signed [sws_pkg::SAMPLE_W-1:0]  rd_a_ff;
   logic signed [sws_pkg::SAMPLE_W-1:0]  rd_b_ff;

   logic [sws_pkg::CNT_W-1:0]            cand_ff;
   logic [sws_pkg::CNT_W-1:0]            j_ff;
   logic                                 pend_ff;
   logic [sws_pkg::CNT_W-1:0]            lt_ff;
   logic [sws_pkg::CNT_W-1:0]            le_ff;
   logic [sws_pkg::CNT_W-1:0]            k_lo_ff;
   logic [sws_pkg::CNT_W-1:0]            k_hi_ff;
   logic signed [sws_pkg::SAMPLE_W-1:0]  lo_ff;
   logic signed [sws_pkg::SAMPLE_W-1:0]  hi_ff;

   logic                                 rsp_valid_ff;
   logic [sws_pkg::WLEN_W-1:0]           rsp_count_ff;
   logic signed [sws_pkg::SUM_W-1:0]     rsp_sum_ff;
   logic signed [sws_pkg::SAMPLE_W-1:0]  rsp_mean_ff;
   logic signed [sws_pkg::SAMPLE_W-1:0]  rsp_med_ff;

   logic [sws_pkg::CNT_W-1:0]            limit;
   logic [sws_pkg::PTR_W-1:0]            addr_a;
   logic [sws_pkg::PTR_W-1:0]            addr_b;
   logic [sws_pkg::PTR_W-1:0]            addr_w;
   logic signed [sws_pkg::ACC_W-1:0]     old_ext;
   logic signed [sws_pkg::ACC_W-1:0]     new_ext;
   logic [sws_pkg::CNT_W-1:0]            half_n;
   logic [sws_pkg::SAMPLE_W:0]           med_sum;
   logic                                 div_done;
   logic signed [sws_pkg::SAMPLE_W-1:0]  div_q;

   // Effective window length: zero or oversize means full depth
   always_comb begin
      if (wlen_ff == '0 || int'(wlen_ff) > sws_pkg::MAX_WINDOW) begin
         limit = sws_pkg::CNT_W'(sws_pkg::MAX_WINDOW);
      end else begin
         limit = sws_pkg::CNT_W'(wlen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= sws_pkg::WLEN_RESET;
      end else if (csr_write_en) begin
         wlen_ff <= csr_write_data;
      end
   end

   // Store addressing
   assign addr_a  = cmd.evict_rd ? ptr_ff : sws_pkg::wrap_add(ptr_ff, cand_ff);
   assign addr_b  = sws_pkg::wrap_add(ptr_ff, j_ff);
   assign addr_w  = sws_pkg::wrap_add(ptr_ff, held_ff);
   assign old_ext = sws_pkg::ACC_W'(rd_a_ff);
   assign new_ext = sws_pkg::ACC_W'(sample_ff);

   // Sample store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[addr_w] <= sample_ff;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
   end

   // Window state: count, oldest pointer, running sum
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         held_ff <= '0;
         ptr_ff  <= '0;
         sum_ff  <= '0;
      end else if (cmd.evict) begin
         held_ff <= held_ff - 1'b1;
         ptr_ff  <= sws_pkg::wrap_add(ptr_ff, sws_pkg::CNT_W'(1));
         sum_ff  <= sum_ff - old_ext;
      end else if (cmd.append) begin
         held_ff <= held_ff + 1'b1;
         sum_ff  <= sum_ff + new_ext;
      end
   end

   // Rank-count median: for each candidate, count entries below and not above it
   assign half_n = held_ff >> 1;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cand_ff <= '0;
         j_ff    <= '0;
         pend_ff <= 1'b0;
         lt_ff   <= '0;
         le_ff   <= '0;
         k_hi_ff <= half_n;
         k_lo_ff <= held_ff[0] ? half_n : half_n - 1'b1;
      end else if (cmd.sweep) begin
         if (j_ff != held_ff) begin
            j_ff    <= j_ff + 1'b1;
            pend_ff <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
         if (pend_ff) begin
            if (rd_b_ff < rd_a_ff) begin
               lt_ff <= lt_ff + 1'b1;
            end
            if (rd_b_ff <= rd_a_ff) begin
               le_ff <= le_ff + 1'b1;
            end
         end
      end else if (cmd.rank) begin
         if (lt_ff <= k_lo_ff && k_lo_ff < le_ff) begin
            lo_ff <= rd_a_ff;
         end
         if (lt_ff <= k_hi_ff && k_hi_ff < le_ff) begin
            hi_ff <= rd_a_ff;
         end
         cand_ff <= cand_ff + 1'b1;
         j_ff    <= '0;
         pend_ff <= 1'b0;
         lt_ff   <= '0;
         le_ff   <= '0;
      end
   end

   // Two middle values added, arithmetic shift right by one
   assign med_sum = {lo_ff[sws_pkg::SAMPLE_W-1], lo_ff} + {hi_ff[sws_pkg::SAMPLE_W-1], hi_ff};

   sws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (sum_ff),
      .divisor  (held_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_count_ff <= sws_pkg::WLEN_W'(held_ff);
         rsp_sum_ff   <= sum_ff[sws_pkg::SUM_W-1:0];
         if (held_ff == '0) begin
            rsp_mean_ff <= '0;
            rsp_med_ff  <= '0;
         end else begin
            rsp_mean_ff <= div_q;
            rsp_med_ff  <= med_sum[sws_pkg::SAMPLE_W:1];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_window_sum   = rsp_sum_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_middle_value = rsp_med_ff;

   // Status to controller
   always_comb begin
      sts.full       = (held_ff >= limit) && (held_ff != '0);
      sts.sweep_done = (j_ff == held_ff) && !pend_ff;
      sts.last_cand  = (cand_ff == held_ff - 1'b1);
      sts.div_done   = div_done;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ----- rtl/sws_ctrl.sv -----
// Controller state machine: sequences capture, clear, eviction, append, median search and result load.
// Depends on sws_pkg.
module sws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  sws_pkg::dp_sts_type  sts,
   output sws_pkg::dp_cmd_type  cmd
);

   sws_pkg::ctrl_state_type state_ff;
   sws_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sws_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == sws_pkg::ACTION_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in  = sws_pkg::ST_FINISH;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = sws_pkg::ST_EVICT_RD;
               end
            end
         end
         sws_pkg::ST_EVICT_RD: begin
            if (sts.full) begin
               cmd.evict_rd = 1'b1;
               state_in     = sws_pkg::ST_EVICT_UPD;
            end else begin
               state_in = sws_pkg::ST_APPEND;
            end
         end
         sws_pkg::ST_EVICT_UPD: begin
            cmd.evict = 1'b1;
            state_in  = sws_pkg::ST_APPEND;
         end
         sws_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = sws_pkg::ST_START;
         end
         sws_pkg::ST_START: begin
            cmd.start = 1'b1;
            state_in  = sws_pkg::ST_SWEEP;
         end
         sws_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in = sws_pkg::ST_RANK;
            end
         end
         sws_pkg::ST_RANK: begin
            cmd.rank = 1'b1;
            state_in = sts.last_cand ? sws_pkg::ST_FINISH : sws_pkg::ST_SWEEP;
         end
         sws_pkg::ST_FINISH: begin
            if (sts.div_done && sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = sws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sws_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
